// ----- rtl/core/dtshd_pkg.sv -----
package dtshd_pkg;

    localparam int PH_W = 44;

    // one-hot parse phases, bit index follows the parse order
    typedef enum logic [PH_W-1:0] {
        P_CSYNC    = 44'd1 << 0,
        P_CSKIP1   = 44'd1 << 1,
        P_FSIZE    = 44'd1 << 2,
        P_CSKIP2   = 44'd1 << 3,
        P_EXTID    = 44'd1 << 4,
        P_EXTAUD   = 44'd1 << 5,
        P_ASPF     = 44'd1 << 6,
        P_LFF      = 44'd1 << 7,
        P_WAIT_SS  = 44'd1 << 8,
        P_SSYNC    = 44'd1 << 9,
        P_USER     = 44'd1 << 10,
        P_IDX      = 44'd1 << 11,
        P_HST      = 44'd1 << 12,
        P_HDR      = 44'd1 << 13,
        P_SSF      = 44'd1 << 14,
        P_STATIC   = 44'd1 << 15,
        P_SKIP5    = 44'd1 << 16,
        P_TSF      = 44'd1 << 17,
        P_TS       = 44'd1 << 18,
        P_NPRES    = 44'd1 << 19,
        P_NAST     = 44'd1 << 20,
        P_MASK     = 44'd1 << 21,
        P_AMASK    = 44'd1 << 22,
        P_MIXEN    = 44'd1 << 23,
        P_MIXADJ   = 44'd1 << 24,
        P_MIXBITS  = 44'd1 << 25,
        P_MIXN     = 44'd1 << 26,
        P_MIXCH    = 44'd1 << 27,
        P_ASZ      = 44'd1 << 28,
        P_ADESC    = 44'd1 << 29,
        P_TYPEF    = 44'd1 << 30,
        P_TYPE     = 44'd1 << 31,
        P_LANGF    = 44'd1 << 32,
        P_LANG     = 44'd1 << 33,
        P_TEXTF    = 44'd1 << 34,
        P_TEXTN    = 44'd1 << 35,
        P_TEXT     = 44'd1 << 36,
        P_RES      = 44'd1 << 37,
        P_RATE     = 44'd1 << 38,
        P_CHS      = 44'd1 << 39,
        P_WAIT_CRC = 44'd1 << 40,
        P_CRC      = 44'd1 << 41,
        P_HALT     = 44'd1 << 42,
        P_END      = 44'd1 << 43
    } phase_t;

    // phases from substream sync through waiting for the crc word
    localparam logic [PH_W-1:0] PH_SS_RANGE =
        ((44'd1 << 41) - 44'd1) & ~((44'd1 << 9) - 44'd1);

    typedef enum logic [3:0] {
        ST_OK_EXT    = 4'd0,
        ST_OK_CORE   = 4'd1,
        ST_NOT_DTS   = 4'd2,
        ST_SHORT     = 4'd3,
        ST_CORE_SYNC = 4'd4,
        ST_CORE_SIZE = 4'd5,
        ST_CORE_EXT  = 4'd6,
        ST_SHORT_SS  = 4'd7,
        ST_SS_SYNC   = 4'd8,
        ST_SS_SIZE   = 4'd9,
        ST_MULTI     = 4'd10,
        ST_CRC       = 4'd11
    } status_t;

    localparam int COUNT_BITS_DEF      = 21;
    localparam int MIN_FRAME_BYTES_DEF = 94;

    localparam logic [31:0] CORE_SYNC_WORD = 32'h7FFE_8001;
    localparam logic [31:0] SS_SYNC_WORD   = 32'h6458_2025;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [14:0] CORE_HDR_MIN   = 15'd11;
    localparam int          SS_MIN_BYTES   = 12;

    typedef struct packed {
        logic [1:0]  idx;
        logic        wide;
        logic [12:0] hdr;
        logic        hdr_known;
        logic [20:0] ssf;
        logic [4:0]  mixbits;
        logic [5:0]  res;
        logic [3:0]  rate;
        logic [8:0]  chs;
        logic [15:0] crc_rx;
    } ss_fields_t;

    typedef struct packed {
        logic [3:0] mask;
        logic [2:0] bitpos;
        logic [2:0] left;
    } loops_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] shift;
        logic [13:0] left;
        logic [14:0] core_size;
        logic [1:0]  lfe;
        ss_fields_t  fields;
        loops_t      loops;
        logic [15:0] crc;
        status_t     err;
    } parse_t;

    localparam parse_t PARSE_CLEAR = '{
        phase:     P_CSYNC,
        shift:     32'd0,
        left:      14'd32,
        core_size: 15'd0,
        lfe:       2'd0,
        fields:    '0,
        loops:     '0,
        crc:       CRC_INIT,
        err:       ST_OK_EXT
    };

    function automatic logic [18:0] rate_hz(input logic [3:0] code);
        logic [18:0] r;
        case (code)
            4'd0:    r = 19'd8000;
            4'd1:    r = 19'd16000;
            4'd2:    r = 19'd32000;
            4'd3:    r = 19'd64000;
            4'd4:    r = 19'd128000;
            4'd5:    r = 19'd22050;
            4'd6:    r = 19'd44100;
            4'd7:    r = 19'd88200;
            4'd8:    r = 19'd176400;
            4'd9:    r = 19'd352800;
            4'd10:   r = 19'd12000;
            4'd11:   r = 19'd24000;
            4'd12:   r = 19'd48000;
            4'd13:   r = 19'd96000;
            4'd14:   r = 19'd192000;
            default: r = 19'd384000;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/dts_hd_header_parser.sv -----
// Timing: one frame byte per transfer; the result for a frame appears on the
// master side in the cycle after its last byte is taken.
// Throughput: one byte per cycle; all field extraction and the crc byte update
// for a byte run in one pass against the parse state registers. Input stalls
// only while a finished result waits on the master side.
// Reset: synchronous active-low aresetn clears the parse state and output valid
// and sets the held stream info to invalid with LFE unknown.
module dts_hd_header_parser #(
    parameter int COUNT_BITS      = dtshd_pkg::COUNT_BITS_DEF,
    parameter int MIN_FRAME_BYTES = dtshd_pkg::MIN_FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    input  logic [0:0]  s_tuser,   // [0] codec_is_dts
    output logic        m_tvalid,
    input  logic        m_tready,
    // [8:0] total_channels, [14:9] bit_resolution, [33:15] sample_rate_hz,
    // [35:34] lfe_state, [39:36] zero
    output logic [39:0] m_tdata,
    output logic [4:0]  m_tuser    // [3:0] status, [4] ext_valid
);
    import dtshd_pkg::*;

    localparam int SUM_W = (COUNT_BITS > 21 ? COUNT_BITS : 21) + 2;

    parse_t st_reg, st_next;
    logic [COUNT_BITS-1:0] pos_reg, pos_next;

    logic        hv_reg;
    logic [8:0]  hchs_reg;
    logic [5:0]  hres_reg;
    logic [18:0] hrate_reg;
    logic [1:0]  hlfe_reg;

    logic        out_valid_reg;
    status_t     out_status_reg;

    status_t     status;
    logic [SUM_W-1:0] n, core, ssf;
    logic        s_xfer;

    dtshd_byte_step #(.COUNT_BITS(COUNT_BITS)) u_step (
        .st_i   (st_reg),
        .pos_i  (pos_reg),
        .byte_i (s_tdata),
        .st_o   (st_next)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign pos_next = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;

    always_comb begin
        n    = SUM_W'(pos_next);
        core = SUM_W'(st_next.core_size);
        ssf  = SUM_W'(st_next.fields.ssf);
        if (!s_tuser[0])                               status = ST_NOT_DTS;
        else if (n < SUM_W'(MIN_FRAME_BYTES))          status = ST_SHORT;
        else if (st_next.err == ST_CORE_SYNC)          status = ST_CORE_SYNC;
        else if (core > n)                             status = ST_CORE_SIZE;
        else if (st_next.err == ST_CORE_EXT)           status = ST_CORE_EXT;
        else if (core == n)                            status = ST_OK_CORE;
        else if (n < core + SUM_W'(SS_MIN_BYTES))      status = ST_SHORT_SS;
        else if (st_next.err == ST_SS_SYNC)            status = ST_SS_SYNC;
        else if (core + ssf != n)                      status = ST_SS_SIZE;
        else if (st_next.err == ST_MULTI || st_next.err == ST_CRC)
                                                       status = st_next.err;
        else if (st_next.phase != P_END)               status = ST_SS_SIZE;
        else if (st_next.fields.crc_rx != st_next.crc) status = ST_CRC;
        else                                           status = ST_OK_EXT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= PARSE_CLEAR;
            pos_reg        <= '0;
            hv_reg         <= 1'b0;
            hchs_reg       <= 9'd0;
            hres_reg       <= 6'd0;
            hrate_reg      <= 19'd0;
            hlfe_reg       <= 2'd2;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK_EXT;
        end else begin
            if (s_xfer && s_tlast) out_valid_reg <= 1'b1;
            else if (m_tready)     out_valid_reg <= 1'b0;
            if (s_xfer) begin
                if (s_tlast) begin
                    st_reg         <= PARSE_CLEAR;
                    pos_reg        <= '0;
                    out_status_reg <= status;
                    if (status == ST_OK_EXT) begin
                        hv_reg    <= 1'b1;
                        hchs_reg  <= st_next.fields.chs;
                        hres_reg  <= st_next.fields.res;
                        hrate_reg <= rate_hz(st_next.fields.rate);
                        hlfe_reg  <= (st_next.lfe == 2'd0) ? 2'd0 :
                                     (st_next.lfe == 2'd3) ? 2'd2 : 2'd1;
                    end else if (status != ST_OK_CORE) begin
                        hv_reg    <= 1'b0;
                        hchs_reg  <= 9'd0;
                        hres_reg  <= 6'd0;
                        hrate_reg <= 19'd0;
                        hlfe_reg  <= 2'd2;
                    end
                end else begin
                    st_reg  <= st_next;
                    pos_reg <= pos_next;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, hlfe_reg, hrate_reg, hres_reg, hchs_reg};
    assign m_tuser  = {hv_reg, out_status_reg};

endmodule

// ----- rtl/core/dtshd_byte_step.sv -----
module dtshd_byte_step #(
    parameter int COUNT_BITS = dtshd_pkg::COUNT_BITS_DEF
) (
    input  dtshd_pkg::parse_t  st_i,
    input  logic [COUNT_BITS-1:0] pos_i,
    input  logic [7:0]         byte_i,
    output dtshd_pkg::parse_t  st_o
);
    import dtshd_pkg::*;

    localparam int OW = COUNT_BITS + 4;

    function automatic parse_t go(parse_t s, phase_t ph, logic [13:0] w);
        parse_t r;
        r = s;
        r.phase = ph;
        r.left  = w;
        r.shift = 32'd0;
        return r;
    endfunction

    function automatic parse_t halt(parse_t s, status_t code);
        parse_t r;
        r = s;
        r.err   = code;
        r.phase = P_HALT;
        return r;
    endfunction

    function automatic parse_t next_amask(parse_t s);
        parse_t r;
        logic   hit;
        logic [2:0] kk;
        r   = s;
        hit = 1'b0;
        kk  = 3'd0;
        for (int k = 3; k >= 0; k--) begin
            if (3'(k) >= s.loops.bitpos && 2'(k) <= s.fields.idx && s.loops.mask[k]) begin
                hit = 1'b1;
                kk  = 3'(k);
            end
        end
        if (hit) begin
            r.loops.bitpos = kk + 3'd1;
            r = go(r, P_AMASK, 14'd8);
        end else begin
            if (s.loops.bitpos <= {1'b0, s.fields.idx})
                r.loops.bitpos = {1'b0, s.fields.idx} + 3'd1;
            r = go(r, P_MIXEN, 14'd1);
        end
        return r;
    endfunction

    function automatic parse_t bit_step(parse_t s, logic bv, logic [2:0] b,
                                        logic [COUNT_BITS-1:0] pos);
        parse_t r;
        logic [31:0] v;
        logic [13:0] aszw;
        logic [COUNT_BITS-1:0] off;
        logic [OW-1:0] used;
        logic [OW-1:0] limit;
        r = s;
        if (s.phase == P_WAIT_SS || s.phase == P_WAIT_CRC ||
            s.phase == P_HALT || s.phase == P_END) begin
            return r;
        end
        r.shift = {s.shift[30:0], bv};
        if (r.left != 14'd0) r.left = r.left - 14'd1;
        if (r.left != 14'd0) return r;
        v    = r.shift;
        aszw = r.fields.wide ? 14'd20 : 14'd16;
        off  = (pos >= COUNT_BITS'(s.core_size)) ? pos - COUNT_BITS'(s.core_size)
                                                 : '0;
        used  = {1'b0, off, 3'b000} + OW'(b) + OW'(17);
        limit = OW'({r.fields.hdr, 3'b000});
        case (r.phase)
            P_CSYNC:  r = (v != CORE_SYNC_WORD) ? halt(r, ST_CORE_SYNC)
                                                : go(r, P_CSKIP1, 14'd14);
            P_CSKIP1: r = go(r, P_FSIZE, 14'd14);
            P_FSIZE: begin
                r.core_size = {1'b0, v[13:0]} + 15'd1;
                r = go(r, P_CSKIP2, 14'd20);
            end
            P_CSKIP2: r = go(r, P_EXTID, 14'd3);
            P_EXTID:  r = go(r, P_EXTAUD, 14'd1);
            P_EXTAUD: r = (v != 32'd0) ? halt(r, ST_CORE_EXT) : go(r, P_ASPF, 14'd1);
            P_ASPF:   r = go(r, P_LFF, 14'd2);
            P_LFF: begin
                r.lfe = v[1:0];
                if (r.core_size < CORE_HDR_MIN) r = halt(r, ST_SS_SYNC);
                else r.phase = P_WAIT_SS;
            end
            P_SSYNC:  r = (v != SS_SYNC_WORD) ? halt(r, ST_SS_SYNC)
                                              : go(r, P_USER, 14'd8);
            P_USER:   r = go(r, P_IDX, 14'd2);
            P_IDX: begin
                r.fields.idx = v[1:0];
                r = go(r, P_HST, 14'd1);
            end
            P_HST: begin
                r.fields.wide = v[0];
                r = go(r, P_HDR, v[0] ? 14'd12 : 14'd8);
            end
            P_HDR: begin
                r.fields.hdr       = {1'b0, v[11:0]} + 13'd1;
                r.fields.hdr_known = 1'b1;
                r = go(r, P_SSF, aszw);
            end
            P_SSF: begin
                r.fields.ssf = {1'b0, v[19:0]} + 21'd1;
                r = go(r, P_STATIC, 14'd1);
            end
            P_STATIC: r = (v == 32'd0) ? halt(r, ST_MULTI) : go(r, P_SKIP5, 14'd5);
            P_SKIP5:  r = go(r, P_TSF, 14'd1);
            P_TSF:    r = (v != 32'd0) ? go(r, P_TS, 14'd36) : go(r, P_NPRES, 14'd3);
            P_TS:     r = go(r, P_NPRES, 14'd3);
            P_NPRES: begin
                r.loops.left = v[2:0];
                r = go(r, P_NAST, 14'd3);
            end
            P_NAST: begin
                if (r.loops.left != 3'd0 || v != 32'd0) r = halt(r, ST_MULTI);
                else r = go(r, P_MASK, 14'({1'b0, r.fields.idx} + 3'd1));
            end
            P_MASK: begin
                r.loops.mask   = v[3:0];
                r.loops.bitpos = 3'd0;
                r = next_amask(r);
            end
            P_AMASK:  r = next_amask(r);
            P_MIXEN:  r = (v != 32'd0) ? go(r, P_MIXADJ, 14'd2) : go(r, P_ASZ, aszw);
            P_MIXADJ: r = go(r, P_MIXBITS, 14'd2);
            P_MIXBITS: begin
                r.fields.mixbits = {({1'b0, v[1:0]} + 3'd1), 2'b00};
                r = go(r, P_MIXN, 14'd2);
            end
            P_MIXN: begin
                r.loops.left = {1'b0, v[1:0]};
                r = go(r, P_MIXCH, 14'(r.fields.mixbits));
            end
            P_MIXCH: begin
                if (r.loops.left != 3'd0) begin
                    r.loops.left = r.loops.left - 3'd1;
                    r = go(r, P_MIXCH, 14'(r.fields.mixbits));
                end else begin
                    r = go(r, P_ASZ, aszw);
                end
            end
            P_ASZ:   r = go(r, P_ADESC, 14'd12);
            P_ADESC: r = go(r, P_TYPEF, 14'd1);
            P_TYPEF: r = (v != 32'd0) ? go(r, P_TYPE, 14'd4) : go(r, P_LANGF, 14'd1);
            P_TYPE:  r = go(r, P_LANGF, 14'd1);
            P_LANGF: r = (v != 32'd0) ? go(r, P_LANG, 14'd24) : go(r, P_TEXTF, 14'd1);
            P_LANG:  r = go(r, P_TEXTF, 14'd1);
            P_TEXTF: r = (v != 32'd0) ? go(r, P_TEXTN, 14'd10) : go(r, P_RES, 14'd5);
            P_TEXTN: r = go(r, P_TEXT, {({1'b0, v[9:0]} + 11'd1), 3'b000});
            P_TEXT:  r = go(r, P_RES, 14'd5);
            P_RES: begin
                r.fields.res = {1'b0, v[4:0]} + 6'd1;
                r = go(r, P_RATE, 14'd4);
            end
            P_RATE: begin
                r.fields.rate = v[3:0];
                r = go(r, P_CHS, 14'd8);
            end
            P_CHS: begin
                r.fields.chs = {1'b0, v[7:0]} + 9'd1;
                // header fields must leave room for the crc word
                if (used > limit) r = halt(r, ST_CRC);
                else r.phase = P_WAIT_CRC;
            end
            P_CRC: begin
                r.fields.crc_rx = v[15:0];
                r.phase = P_END;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] d);
        logic [15:0] x;
        x = c ^ {d, 8'h00};
        for (int k = 0; k < 8; k++)
            x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
        return x;
    endfunction

    parse_t s0;
    parse_t s1;
    logic [COUNT_BITS-1:0] off0;
    logic [COUNT_BITS:0]   off2;

    always_comb begin
        s0 = st_i;
        if (s0.phase == P_WAIT_SS && pos_i == COUNT_BITS'(s0.core_size))
            s0 = go(s0, P_SSYNC, 14'd32);
        off0 = pos_i - COUNT_BITS'(s0.core_size);
        off2 = {1'b0, off0} + (COUNT_BITS+1)'(2);
        if (s0.phase == P_WAIT_CRC && pos_i >= COUNT_BITS'(s0.core_size) &&
            off2 == (COUNT_BITS+1)'(s0.fields.hdr))
            s0 = go(s0, P_CRC, 14'd16);

        // crc covers header bytes 5 .. hdr-3
        if ((s0.phase & PH_SS_RANGE) != '0 && pos_i >= COUNT_BITS'(s0.core_size) &&
            off0 >= COUNT_BITS'(5) &&
            (!s0.fields.hdr_known || off2 < (COUNT_BITS+1)'(s0.fields.hdr)))
            s0.crc = crc_byte(s0.crc, byte_i);

        s1 = s0;
        for (int b = 0; b < 8; b++)
            s1 = bit_step(s1, byte_i[7-b], 3'(b), pos_i);
        st_o = s1;
    end

endmodule
